[hdl/led_driver_frame_serializer_unit_macros.svh]
// assertion macros for the led driver frame serializer checker
`ifndef LED_DRIVER_FRAME_SERIALIZER_UNIT_MACROS_SVH
`define LED_DRIVER_FRAME_SERIALIZER_UNIT_MACROS_SVH

// condition in this cycle implies consequence in the same cycle
`define LFS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfs check failed: same cycle");

// condition in this cycle implies consequence in the next cycle
`define LFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfs check failed: next cycle");

`endif

[hdl/lfs_pkg.sv]
// shared types and constants for the led driver frame serializer
package lfs_pkg;

    // default number of digit bytes
    localparam int DIGIT_COUNT_DEF = 5;

    // register reset values
    localparam logic [7:0] DATA_CMD_RST  = 8'h40;
    localparam logic [7:0] ADDR_CMD_RST  = 8'hC0;
    localparam logic [7:0] LEAD_BYTE_RST = 8'hFF;
    localparam logic [7:0] DISP_CTL_RST  = 8'h8B;

    // configuration register indexes
    localparam logic [1:0] CFG_DATA_CMD  = 2'd0;
    localparam logic [1:0] CFG_ADDR_CMD  = 2'd1;
    localparam logic [1:0] CFG_LEAD_BYTE = 2'd2;
    localparam logic [1:0] CFG_DISP_CTL  = 2'd3;

    // bit count of one byte and the acknowledge slot index
    localparam logic [3:0] ACK_SLOT = 4'd8;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_START = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_START = 2'd1,
        ST_BYTE  = 2'd2,
        ST_STOP  = 2'd3
    } t_stage;

    typedef struct packed {
        logic [1:0] action;
        logic [2:0] digit_index;
        logic [7:0] digit_value;
        logic       bus_busy;
    } t_in_item;

    typedef struct packed {
        logic clock_line;
        logic data_line;
        logic refresh_busy;
        logic frame_done;
    } t_out_item;

    typedef struct packed {
        logic [7:0] data_command;
        logic [7:0] address_command;
        logic [7:0] lead_byte;
        logic [7:0] display_control;
    } t_cfg;

endpackage

[hdl/lfs_core.sv]
// frame sequencer: digit store, line step state machine and result logic
module lfs_core #(
    parameter int DIGIT_COUNT = lfs_pkg::DIGIT_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  lfs_pkg::t_in_item i_item,
    input  lfs_pkg::t_cfg     i_cfg,
    output lfs_pkg::t_out_item o_result
);
    import lfs_pkg::*;

    localparam int BPW = $clog2(DIGIT_COUNT + 3);
    localparam int DIW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam logic [BPW-1:0] LAST_POS  = BPW'(DIGIT_COUNT + 1);
    localparam logic [BPW-1:0] DIGIT_LEN = BPW'(DIGIT_COUNT + 2);
    localparam logic [3:0]     DIGIT_LIM = 4'(DIGIT_COUNT);

    // state registers
    logic [7:0]     r_digit [DIGIT_COUNT];
    t_stage         r_stage,    n_stage;
    logic [1:0]     r_trans,    n_trans;
    logic [BPW-1:0] r_bpos,     n_bpos;
    logic [3:0]     r_bit,      n_bit;
    logic [1:0]     r_phase,    n_phase;
    logic [7:0]     r_shift,    n_shift;
    logic           r_clk_lvl,  n_clk_lvl;
    logic           r_dat_lvl,  n_dat_lvl;
    logic           n_done;

    // byte selection for the byte about to begin
    logic [BPW-1:0] w_sel_pos;
    logic [BPW-1:0] w_dig_off;
    logic [DIW-1:0] w_dig_idx;
    logic [7:0]     w_sel_byte;
    logic [BPW-1:0] w_bpos_inc;
    logic [BPW-1:0] w_bytes_in;
    logic [DIW-1:0] w_load_idx;

    assign w_load_idx = DIW'(i_item.digit_index);
    assign w_bpos_inc = r_bpos + BPW'(1);
    assign w_bytes_in = (r_trans == 2'd1) ? DIGIT_LEN : BPW'(1);
    // a byte begins at position zero after a start, or at the next position after an ack
    assign w_sel_pos  = (r_stage == ST_BYTE) ? w_bpos_inc : '0;
    assign w_dig_off  = (w_sel_pos == LAST_POS) ? '0 : (w_sel_pos - BPW'(1));
    assign w_dig_idx  = w_dig_off[DIW-1:0];

    always_comb begin
        if (r_trans == 2'd0) begin
            w_sel_byte = i_cfg.data_command;
        end else if (r_trans != 2'd1) begin
            w_sel_byte = i_cfg.display_control;
        end else if (w_sel_pos == '0) begin
            w_sel_byte = i_cfg.address_command;
        end else if (w_sel_pos == BPW'(1)) begin
            w_sel_byte = i_cfg.lead_byte;
        end else begin
            w_sel_byte = r_digit[w_dig_idx];
        end
    end

    // next state of the line sequencer
    always_comb begin
        n_stage   = r_stage;
        n_trans   = r_trans;
        n_bpos    = r_bpos;
        n_bit     = r_bit;
        n_phase   = r_phase;
        n_shift   = r_shift;
        n_clk_lvl = r_clk_lvl;
        n_dat_lvl = r_dat_lvl;
        n_done    = 1'b0;
        case (t_action'(i_item.action))
            ACT_TICK: begin
                case (r_stage)
                    ST_START: begin
                        case (r_phase)
                            2'd0: begin
                                n_clk_lvl = 1'b1;
                                n_phase   = 2'd1;
                            end
                            2'd1: begin
                                n_dat_lvl = 1'b1;
                                n_phase   = 2'd2;
                            end
                            2'd2: begin
                                n_dat_lvl = 1'b0;
                                n_phase   = 2'd3;
                            end
                            default: begin
                                n_clk_lvl = 1'b0;
                                n_bpos    = '0;
                                n_stage   = ST_BYTE;
                                n_bit     = '0;
                                n_phase   = 2'd0;
                                n_shift   = w_sel_byte;
                            end
                        endcase
                    end
                    ST_BYTE: begin
                        case (r_phase)
                            2'd0: begin
                                n_clk_lvl = 1'b0;
                                n_phase   = 2'd1;
                            end
                            2'd1: begin
                                n_dat_lvl = (r_bit < ACK_SLOT) ? r_shift[0] : 1'b1;
                                n_phase   = 2'd2;
                            end
                            default: begin
                                n_clk_lvl = 1'b1;
                                n_phase   = 2'd0;
                                if (r_bit < ACK_SLOT) begin
                                    n_shift = {1'b0, r_shift[7:1]};
                                    n_bit   = r_bit + 4'd1;
                                end else begin
                                    n_bpos    = w_bpos_inc;
                                    if (w_bpos_inc < w_bytes_in) begin
                                        n_bit   = '0;
                                        n_shift = w_sel_byte;
                                    end else begin
                                        n_stage = ST_STOP;
                                    end
                                end
                            end
                        endcase
                    end
                    ST_STOP: begin
                        case (r_phase)
                            2'd0: begin
                                n_clk_lvl = 1'b0;
                                n_phase   = 2'd1;
                            end
                            2'd1: begin
                                n_dat_lvl = 1'b0;
                                n_phase   = 2'd2;
                            end
                            2'd2: begin
                                n_clk_lvl = 1'b1;
                                n_phase   = 2'd3;
                            end
                            default: begin
                                n_dat_lvl = 1'b1;
                                n_phase   = 2'd0;
                                if (r_trans < 2'd2) begin
                                    n_trans = r_trans + 2'd1;
                                    n_stage = ST_START;
                                end else begin
                                    n_trans = 2'd0;
                                    n_stage = ST_IDLE;
                                    n_done  = 1'b1;
                                end
                            end
                        endcase
                    end
                    default: ;
                endcase
            end
            ACT_START: begin
                if (!i_item.bus_busy && r_stage == ST_IDLE) begin
                    n_stage = ST_START;
                    n_trans = 2'd0;
                    n_bpos  = '0;
                    n_bit   = '0;
                    n_phase = 2'd0;
                end
            end
            default: ;
        endcase
    end

    // sequencer state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage   <= ST_IDLE;
            r_trans   <= '0;
            r_bpos    <= '0;
            r_bit     <= '0;
            r_phase   <= '0;
            r_shift   <= '0;
            r_clk_lvl <= 1'b1;
            r_dat_lvl <= 1'b1;
        end else if (i_step) begin
            r_stage   <= n_stage;
            r_trans   <= n_trans;
            r_bpos    <= n_bpos;
            r_bit     <= n_bit;
            r_phase   <= n_phase;
            r_shift   <= n_shift;
            r_clk_lvl <= n_clk_lvl;
            r_dat_lvl <= n_dat_lvl;
        end
    end

    // digit store: load one entry or clear all
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                r_digit[i] <= '0;
            end
        end else if (i_step) begin
            if (t_action'(i_item.action) == ACT_CLEAR) begin
                for (int i = 0; i < DIGIT_COUNT; i++) begin
                    r_digit[i] <= '0;
                end
            end else if (t_action'(i_item.action) == ACT_LOAD &&
                         {1'b0, i_item.digit_index} < DIGIT_LIM) begin
                r_digit[w_load_idx] <= i_item.digit_value;
            end
        end
    end

    // result of this transaction
    assign o_result.clock_line   = n_clk_lvl;
    assign o_result.data_line    = n_dat_lvl;
    assign o_result.refresh_busy = (n_stage != ST_IDLE);
    assign o_result.frame_done   = n_done;

endmodule

[hdl/led_driver_frame_serializer_unit.sv]
// led driver frame serializer: item register, sequencer and result register
// an item is held in the input item register, then its result in the result register
// one item per cycle when not stalled; each tick item moves the pins by one line step
// a full refresh frame takes a fixed number of ticks set by the digit count
// reset clears the digit store and sequencer; both pins idle high, registers at defaults
module led_driver_frame_serializer_unit #(
    parameter int DIGIT_COUNT = lfs_pkg::DIGIT_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lfs_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lfs_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data
);
    import lfs_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_cfg      r_cfg;
    t_out_item w_result;
    logic      w_out_free;
    logic      w_step;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_step      = r_in_valid && w_out_free;
    assign o_in_stall  = r_in_valid && !w_out_free;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.data_command    <= DATA_CMD_RST;
            r_cfg.address_command <= ADDR_CMD_RST;
            r_cfg.lead_byte       <= LEAD_BYTE_RST;
            r_cfg.display_control <= DISP_CTL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DATA_CMD:  r_cfg.data_command    <= i_cfg_data;
                CFG_ADDR_CMD:  r_cfg.address_command <= i_cfg_data;
                CFG_LEAD_BYTE: r_cfg.lead_byte       <= i_cfg_data;
                CFG_DISP_CTL:  r_cfg.display_control <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input item register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // sequencer and digit store
    lfs_core #(
        .DIGIT_COUNT(DIGIT_COUNT)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_item <= w_result;
        end
    end

endmodule

[hdl/lfs_checker.sv]
// port-level checker for the led driver frame serializer, with its bind
`include "led_driver_frame_serializer_unit_macros.svh"

module lfs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input lfs_pkg::t_out_item o_out_item
);
    import lfs_pkg::*;

    logic w_done_seen;
    logic w_idle_seen;
    logic w_held;

    assign w_done_seen = o_out_valid && o_out_item.frame_done;
    assign w_idle_seen = o_out_valid && !o_out_item.refresh_busy;
    assign w_held      = o_out_valid && i_out_stall;

    // a finished frame is never reported as still busy
    `LFS_ASSERT_SAME(a_done_not_busy, i_clk, i_rst_n, w_done_seen, !o_out_item.refresh_busy)

    // outside a frame both pins rest high
    `LFS_ASSERT_SAME(a_idle_lines_high, i_clk, i_rst_n, w_idle_seen, &o_out_item[3:2])

    // a stalled result transaction holds
    `LFS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_held, o_out_valid && $stable(o_out_item))

endmodule

bind led_driver_frame_serializer_unit lfs_checker u_lfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
